FILE: src/bam_pkg.sv
// ----------------------------------------------------------------------------
// bam_pkg
// Shared types and codes of the bit angle modulation LED matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bam_pkg;

   // Command codes of the request channel
   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_GET  = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // Kind codes of the response channel
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int ROW_W   = 3;
   localparam int COL_W   = 3;
   localparam int VALUE_W = 8;
   localparam int DIGIT_W = 4;
   localparam int BITS_W  = 8;
   localparam int PLANE_W = 3;
   localparam int TICK_W  = 8;
   // Queued row index is wide enough for the largest row count
   localparam int QROW_W  = 4;

   typedef enum logic [1:0] {
      OP_SET,
      OP_GET,
      OP_DRAIN
   } op_type;

   typedef struct packed {
      op_type               op;
      logic                 row_ok;
      logic [QROW_W-1:0]    row;
      logic [COL_W-1:0]     col;
      logic [VALUE_W-1:0]   value;
      logic [PLANE_W-1:0]   plane;
   } entry_type;

   typedef struct packed {
      logic                 kind;
      logic [DIGIT_W-1:0]   digit_reg;
      logic [BITS_W-1:0]    row_bits;
      logic [VALUE_W-1:0]   pixel_value;
      logic                 last;
   } out_word_type;

   typedef enum logic {
      BK_IDLE,
      BK_DRAIN
   } back_state_type;

endpackage

`default_nettype wire

FILE: src/bam_if.sv
// ----------------------------------------------------------------------------
// bam_if
// Valid/ready channels of the LED matrix unit: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface bam_req_if;
   logic                          valid;
   logic                          ready;
   logic [bam_pkg::CMD_W-1:0]     cmd;
   logic [bam_pkg::ROW_W-1:0]     row;
   logic [bam_pkg::COL_W-1:0]     col;
   logic [bam_pkg::VALUE_W-1:0]   value;

   modport source (output valid, input ready, output cmd, output row, output col,
                   output value);
   modport sink   (input valid, output ready, input cmd, input row, input col,
                   input value);
endinterface

interface bam_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [bam_pkg::DIGIT_W-1:0]   digit_reg;
   logic [bam_pkg::BITS_W-1:0]    row_bits;
   logic [bam_pkg::VALUE_W-1:0]   pixel_value;
   logic                          last;

   modport source (output valid, input ready, output kind, output digit_reg,
                   output row_bits, output pixel_value, output last);
   modport sink   (input valid, output ready, input kind, input digit_reg,
                   input row_bits, input pixel_value, input last);
endinterface

`default_nettype wire

FILE: src/bit_angle_modulation_led_matrix_unit.sv
// ----------------------------------------------------------------------------
// bit_angle_modulation_led_matrix_unit
// Bit angle modulation frame store and row sequencer for an LED matrix.
// ----------------------------------------------------------------------------
// Requests arrive on req_if: set writes one pixel's brightness into the bit
// planes, get reads it back, tick counts one prescaled timer tick. Responses
// leave on rsp_if: a read result (kind 0) for every get, and a burst of ROWS
// row words (kind 1, digit register row + 1, last on the final word) each
// time the tick count reaches 2^plane and the plane index advances.
// The front takes one request per cycle while the two-entry queue is not
// full; the back executes one queued set or get per cycle while idle. A get
// result passes the queue and then the output register. A plane change holds
// the back while it drains the rows, one row word per cycle while the output
// is free, since the row store has a single read port. req_if.ready drops
// only while the queue is full. A stalled response holds in the output
// register; a get and the rows of a plane change wait for it, while sets go
// ahead unless rows are still draining. Reset clears the planes, the tick
// counter, the plane index and the queue; no response is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_angle_modulation_led_matrix_unit #(
   parameter int ROWS   = 8,
   parameter int PLANES = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bam_req_if.sink     req_if,
   bam_rsp_if.source   rsp_if
);

   logic               q_full;
   logic               q_empty;
   logic               push;
   logic               pop;
   bam_pkg::entry_type push_entry;
   bam_pkg::entry_type head;

   bam_front #(
      .ROWS   (ROWS),
      .PLANES (PLANES)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .push   (push),
      .entry  (push_entry)
   );

   bam_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   bam_back #(
      .ROWS   (ROWS),
      .PLANES (PLANES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head    (head),
      .pop     (pop),
      .rsp_if  (rsp_if)
   );

endmodule

`default_nettype wire

FILE: src/bam_front.sv
// ----------------------------------------------------------------------------
// bam_front
// Accepts requests, keeps the tick counter and plane index, queues work.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_front #(
   parameter int ROWS   = 8,
   parameter int PLANES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   bam_req_if.sink                  req_if,
   input  wire logic                q_full,
   output logic                     push,
   output bam_pkg::entry_type       entry
);

   localparam int CMP_W = bam_pkg::QROW_W + 1;

   logic [bam_pkg::TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [bam_pkg::PLANE_W-1:0] plane_index_ff, plane_index_in;
   logic [bam_pkg::TICK_W-1:0]  threshold;
   logic [bam_pkg::TICK_W-1:0]  count_next;
   logic [bam_pkg::PLANE_W-1:0] plane_next;
   logic                        accept;
   logic                        row_ok;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign row_ok       = CMP_W'(req_if.row) < CMP_W'(ROWS);
   assign threshold    = bam_pkg::TICK_W'(1) << plane_index_ff;
   assign count_next   = tick_count_ff + bam_pkg::TICK_W'(1);
   assign plane_next   = (plane_index_ff == bam_pkg::PLANE_W'(PLANES - 1)) ?
                         '0 : plane_index_ff + bam_pkg::PLANE_W'(1);

   always_comb begin
      push           = 1'b0;
      tick_count_in  = tick_count_ff;
      plane_index_in = plane_index_ff;
      entry.op       = bam_pkg::OP_SET;
      entry.row_ok   = row_ok;
      entry.row      = bam_pkg::QROW_W'(req_if.row);
      entry.col      = req_if.col;
      entry.value    = req_if.value;
      entry.plane    = plane_next;
      case (req_if.cmd)
         bam_pkg::CMD_SET: begin
            // drop a write beyond the last row
            push     = accept && row_ok;
            entry.op = bam_pkg::OP_SET;
         end
         bam_pkg::CMD_GET: begin
            push     = accept;
            entry.op = bam_pkg::OP_GET;
         end
         bam_pkg::CMD_TICK: begin
            entry.op = bam_pkg::OP_DRAIN;
            if (accept) begin
               if (count_next >= threshold) begin
                  tick_count_in  = '0;
                  plane_index_in = plane_next;
                  push           = 1'b1;
               end else begin
                  tick_count_in  = count_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         plane_index_ff <= '0;
      end else begin
         tick_count_ff  <= tick_count_in;
         plane_index_ff <= plane_index_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/bam_queue.sv
// ----------------------------------------------------------------------------
// bam_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bam_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output bam_pkg::entry_type       head,
   output logic                     full,
   output logic                     empty
);

   bam_pkg::entry_type entries_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/bam_back.sv
// ----------------------------------------------------------------------------
// bam_back
// Holds the bit planes, carries out set, get and row drain, drives responses.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_back #(
   parameter int ROWS   = 8,
   parameter int PLANES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire bam_pkg::entry_type  head,
   output logic                     pop,
   bam_rsp_if.source                rsp_if
);

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PW = PLANES * bam_pkg::BITS_W;

   // One word per row, holding that row of every plane
   logic [PW-1:0]                plane_rows_ff [ROWS];
   logic [PW-1:0]                rd_word;
   logic [PW-1:0]                wr_word_in;
   logic                         we;
   logic [RW-1:0]                addr;
   logic [bam_pkg::VALUE_W-1:0]  got;

   bam_pkg::back_state_type      state_ff, state_in;
   logic [RW-1:0]                cnt_ff, cnt_in;
   logic [bam_pkg::PLANE_W-1:0]  plane_ff, plane_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   bam_pkg::out_word_type        out_ff, out_in;
   logic                         out_free;
   logic                         last_row;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign addr     = (state_ff == bam_pkg::BK_DRAIN) ? cnt_ff : head.row[RW-1:0];
   assign rd_word  = plane_rows_ff[addr];
   assign last_row = cnt_ff == RW'(ROWS - 1);

   always_comb begin
      wr_word_in = rd_word;
      got        = '0;
      for (int p = 0; p < PLANES; p++) begin
         wr_word_in[p * bam_pkg::BITS_W + int'(head.col)] = head.value[p];
         got[p] = rd_word[p * bam_pkg::BITS_W + int'(head.col)];
      end
      // a row beyond the matrix reads back as zero
      if (!head.row_ok) begin
         got = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      plane_in     = plane_ff;
      pop          = 1'b0;
      we           = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      out_in       = out_ff;
      case (state_ff)
         bam_pkg::BK_IDLE: begin
            if (!q_empty) begin
               case (head.op)
                  bam_pkg::OP_SET: begin
                     pop = 1'b1;
                     we  = head.row_ok;
                  end
                  bam_pkg::OP_GET: begin
                     if (out_free) begin
                        pop                = 1'b1;
                        rsp_valid_in       = 1'b1;
                        out_in.kind        = bam_pkg::KIND_READ;
                        out_in.digit_reg   = '0;
                        out_in.row_bits    = '0;
                        out_in.pixel_value = got;
                        out_in.last        = 1'b1;
                     end
                  end
                  bam_pkg::OP_DRAIN: begin
                     pop      = 1'b1;
                     plane_in = head.plane;
                     cnt_in   = '0;
                     state_in = bam_pkg::BK_DRAIN;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         bam_pkg::BK_DRAIN: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               out_in.kind        = bam_pkg::KIND_ROW;
               out_in.digit_reg   = bam_pkg::DIGIT_W'(5'(cnt_ff) + 5'd1);
               out_in.row_bits    = rd_word[int'(plane_ff) * bam_pkg::BITS_W +:
                                            bam_pkg::BITS_W];
               out_in.pixel_value = '0;
               out_in.last        = last_row;
               if (last_row) begin
                  state_in = bam_pkg::BK_IDLE;
               end else begin
                  cnt_in   = cnt_ff + RW'(1);
               end
            end
         end
         default: begin
            state_in = bam_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_rows_ff <= '{default: '0};
      end else if (we) begin
         plane_rows_ff[addr] <= wr_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bam_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      plane_ff <= plane_in;
      out_ff   <= out_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.kind        = out_ff.kind;
   assign rsp_if.digit_reg   = out_ff.digit_reg;
   assign rsp_if.row_bits    = out_ff.row_bits;
   assign rsp_if.pixel_value = out_ff.pixel_value;
   assign rsp_if.last        = out_ff.last;

endmodule

`default_nettype wire

FILE: src/bam_checker.sv
// ----------------------------------------------------------------------------
// bam_checker
// Port-level checks of the LED matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_kind,
   input wire logic [bam_pkg::DIGIT_W-1:0]   rsp_digit_reg,
   input wire logic [bam_pkg::BITS_W-1:0]    rsp_row_bits,
   input wire logic [bam_pkg::VALUE_W-1:0]   rsp_pixel_value,
   input wire logic                          rsp_last
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_read_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == bam_pkg::KIND_READ |->
         rsp_last && rsp_digit_reg == '0 && rsp_row_bits == '0)
      else $error("read result with row fields or without last");

   a_row_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == bam_pkg::KIND_ROW |-> rsp_pixel_value == '0)
      else $error("row word carries a pixel value");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind bit_angle_modulation_led_matrix_unit bam_checker u_bam_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_kind        (rsp_if.kind),
   .rsp_digit_reg   (rsp_if.digit_reg),
   .rsp_row_bits    (rsp_if.row_bits),
   .rsp_pixel_value (rsp_if.pixel_value),
   .rsp_last        (rsp_if.last)
);

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit angle modulation LED matrix unit.
// ----------------------------------------------------------------------------
// Pixel writes, pixel reads, timer ticks and the unused command are pushed
// through the request channel in bursts with random gaps. Meanwhile the
// response channel stalls on a rotating pattern. A behavioural copy of the
// bit planes, the tick counter and the plane index is updated on every
// request transfer. That copy queues the read results and row words the unit
// owes. Each response transfer is checked field by field against the oldest
// queued word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int MATRIX_ROWS = 8;
   localparam int BIT_PLANES  = 8;
   localparam logic [bam_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 420;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 20;

   typedef struct packed {
      logic [bam_pkg::CMD_W-1:0]   cmd;
      logic [bam_pkg::ROW_W-1:0]   row;
      logic [bam_pkg::COL_W-1:0]   col;
      logic [bam_pkg::VALUE_W-1:0] value;
   } matrix_cmd_type;

   logic clock;
   logic reset;

   bam_req_if req_if ();
   bam_rsp_if rsp_if ();

   bit_angle_modulation_led_matrix_unit #(
      .ROWS   (MATRIX_ROWS),
      .PLANES (BIT_PLANES)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Behavioural copy of the frame store and the modulation sequencer
   logic [bam_pkg::BITS_W-1:0]  plane_image [BIT_PLANES][MATRIX_ROWS];
   logic [bam_pkg::PLANE_W-1:0] plane_sel;
   logic [bam_pkg::TICK_W-1:0]  tick_total;

   matrix_cmd_type        cmd_queue [$];
   bam_pkg::out_word_type due_words [$];
   int                    items_total;
   int                    items_accepted;
   int                    mismatch_count;
   int                    burst_left;
   int                    gap_left;
   logic [15:0]           stall_pattern;
   int                    pattern_age;
   int                    idle_cycles;
   bam_pkg::out_word_type want;
   matrix_cmd_type        next_cmd;
   matrix_cmd_type        seen_cmd;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic add_cmd(input logic [bam_pkg::CMD_W-1:0] cmd, input int row,
                          input int col, input int value);
      matrix_cmd_type c;
      c.cmd   = cmd;
      c.row   = bam_pkg::ROW_W'(row);
      c.col   = bam_pkg::COL_W'(col);
      c.value = bam_pkg::VALUE_W'(value);
      cmd_queue.push_back(c);
      items_total++;
   endtask

   // Apply one accepted request to the copy and queue the words it causes
   task automatic track_matrix(input matrix_cmd_type c);
      bam_pkg::out_word_type w;
      int p;
      int r;
      w = '0;
      case (c.cmd)
         bam_pkg::CMD_SET: begin
            if (int'(c.row) < MATRIX_ROWS)
               for (p = 0; p < BIT_PLANES; p++)
                  plane_image[p][c.row][c.col] = c.value[p];
         end
         bam_pkg::CMD_GET: begin
            w.kind = bam_pkg::KIND_READ;
            if (int'(c.row) < MATRIX_ROWS)
               for (p = 0; p < BIT_PLANES; p++)
                  w.pixel_value[p] = plane_image[p][c.row][c.col];
            w.last = 1'b1;
            due_words.push_back(w);
         end
         bam_pkg::CMD_TICK: begin
            tick_total = tick_total + 1'b1;
            if (int'(tick_total) >= (1 << plane_sel)) begin
               tick_total = '0;
               plane_sel  = bam_pkg::PLANE_W'((int'(plane_sel) + 1) % BIT_PLANES);
               for (r = 0; r < MATRIX_ROWS; r++) begin
                  w.kind      = bam_pkg::KIND_ROW;
                  w.digit_reg = bam_pkg::DIGIT_W'(r + 1);
                  w.row_bits  = plane_image[plane_sel][r];
                  w.last      = (r == MATRIX_ROWS - 1);
                  due_words.push_back(w);
               end
            end
         end
         default: begin
            // unused code: no effect
         end
      endcase
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected,
                  actual);
         mismatch_count++;
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.cmd   <= bam_pkg::CMD_SET;
         req_if.row   <= '0;
         req_if.col   <= '0;
         req_if.value <= '0;
         burst_left = 0;
         gap_left   = 0;
         plane_sel  = '0;
         tick_total = '0;
         for (int p = 0; p < BIT_PLANES; p++)
            for (int r = 0; r < MATRIX_ROWS; r++)
               plane_image[p][r] = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            seen_cmd.cmd   = req_if.cmd;
            seen_cmd.row   = req_if.row;
            seen_cmd.col   = req_if.col;
            seen_cmd.value = req_if.value;
            track_matrix(seen_cmd);
            items_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               next_cmd = cmd_queue.pop_front();
               req_if.valid <= 1'b1;
               req_if.cmd   <= next_cmd.cmd;
               req_if.row   <= next_cmd.row;
               req_if.col   <= next_cmd.col;
               req_if.value <= next_cmd.value;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  // leave many bursts back to back
                  gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_pattern = 16'hffff;
         pattern_age   = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_words.size() == 0) begin
               $display("%0t: unexpected transfer: expected none, actual kind %0d digit %0d",
                        $time, rsp_if.kind, rsp_if.digit_reg);
               mismatch_count++;
            end else begin
               want = due_words.pop_front();
               check_field("kind", want.kind, rsp_if.kind);
               check_field("digit_reg", want.digit_reg, rsp_if.digit_reg);
               check_field("row_bits", want.row_bits, rsp_if.row_bits);
               check_field("pixel_value", want.pixel_value, rsp_if.pixel_value);
               check_field("last", want.last, rsp_if.last);
            end
         end
         // rotate the stall pattern, reload it now and then
         pattern_age++;
         if (pattern_age == 48) begin
            pattern_age   = 0;
            stall_pattern = ($urandom_range(0, 9) < 3) ? 16'hffff : 16'($urandom);
         end else begin
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         end
         rsp_if.ready <= stall_pattern[0];
      end
   end

   // Watchdog on transfers of either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      reset          <= 1'b1;
      items_total    = 0;
      items_accepted = 0;
      mismatch_count = 0;
      idle_cycles    = 0;

      // Directed: corners, extreme values, ignored code, first plane changes
      add_cmd(bam_pkg::CMD_GET, 0, 0, 0);
      add_cmd(bam_pkg::CMD_SET, 0, 0, 255);
      add_cmd(bam_pkg::CMD_GET, 0, 0, 0);
      add_cmd(bam_pkg::CMD_SET, 7, 7, 8'h80);
      add_cmd(bam_pkg::CMD_SET, 7, 0, 8'h01);
      add_cmd(bam_pkg::CMD_SET, 0, 7, 8'haa);
      add_cmd(bam_pkg::CMD_SET, 3, 4, 8'h55);
      add_cmd(bam_pkg::CMD_GET, 7, 7, 0);
      add_cmd(bam_pkg::CMD_GET, 7, 0, 0);
      add_cmd(bam_pkg::CMD_GET, 0, 7, 0);
      add_cmd(bam_pkg::CMD_GET, 3, 4, 0);
      add_cmd(CMD_UNUSED, 7, 7, 255);
      add_cmd(bam_pkg::CMD_GET, 7, 7, 0);
      add_cmd(bam_pkg::CMD_GET, 5, 2, 0);
      add_cmd(bam_pkg::CMD_TICK, 0, 0, 0);
      add_cmd(bam_pkg::CMD_TICK, 7, 7, 255);
      add_cmd(bam_pkg::CMD_TICK, 0, 0, 0);
      add_cmd(bam_pkg::CMD_SET, 0, 0, 0);
      add_cmd(bam_pkg::CMD_GET, 0, 0, 0);
      add_cmd(bam_pkg::CMD_TICK, 0, 0, 0);

      // Random: mostly ticks so the plane index wraps through every plane
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 64)
            add_cmd(bam_pkg::CMD_TICK, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 255));
         else if (pick < 85)
            add_cmd(bam_pkg::CMD_SET, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 255));
         else if (pick < 97)
            add_cmd(bam_pkg::CMD_GET, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 255));
         else
            add_cmd(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 255));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != items_total || due_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
src/bam_pkg.sv
src/bam_if.sv
src/bam_front.sv
src/bam_queue.sv
src/bam_back.sv
src/bit_angle_modulation_led_matrix_unit.sv
src/bam_checker.sv
sim/tb_top.sv
